// ===== hdl/fvd_pkg.sv =====
// Shared types and constants of the feature vector distance unit.
`default_nettype none

package fvd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int ROOT_BITS   = ACC_BITS / 2;
    localparam int FRAC_BITS   = 30;
    localparam int KIND_BITS   = 2;

    localparam logic [KIND_BITS-1:0] KIND_EUCLID  = KIND_BITS'(0);
    localparam logic [KIND_BITS-1:0] KIND_SQUARED = KIND_BITS'(1);
    localparam logic [KIND_BITS-1:0] KIND_COSINE  = KIND_BITS'(2);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] elem_a;
        logic signed [SAMPLE_BITS-1:0] elem_b;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic [ACC_BITS-1:0] distance;
        logic                zero_norm;
        logic                saturated;
    } out_item_t;

    typedef struct packed {
        logic [ACC_BITS-1:0]        diff_sq;
        logic signed [ACC_BITS-1:0] dot;
        logic [ACC_BITS-1:0]        norm_a;
        logic [ACC_BITS-1:0]        norm_b;
        logic                       ovf;
    } acc_t;

endpackage

`default_nettype wire

// ===== hdl/fvd_mac.sv =====
// Shared multiplier and saturating adder feeding the four accumulators.
`default_nettype none

module fvd_mac (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [fvd_pkg::SAMPLE_BITS-1:0] a,
    input  wire logic signed [fvd_pkg::SAMPLE_BITS-1:0] b,
    input  wire logic                                   clear,
    output logic                                        done,
    output fvd_pkg::acc_t                               acc
);
    import fvd_pkg::*;

    localparam int OP_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS = 2 * OP_BITS;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = ACC_BITS + 1;

    typedef enum logic [1:0] {TERM_DIFF, TERM_NA, TERM_NB, TERM_DOT} term_t;

    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg;
    term_t                         step_reg, sel_reg;
    logic                          run_reg, pv_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    acc_t                          acc_reg;

    logic signed [OP_BITS-1:0]     d, x, y;
    logic [SUM_BITS-1:0]           acc_ext, term_ext, sum;
    logic                          is_dot, sat;
    logic [ACC_BITS-1:0]           sat_val, new_val;

    always_comb
    begin
        d = OP_BITS'(a_reg) - OP_BITS'(b_reg);
        unique case (step_reg)
            TERM_DIFF:
            begin
                x = d;
                y = d;
            end
            TERM_NA:
            begin
                x = OP_BITS'(a_reg);
                y = OP_BITS'(a_reg);
            end
            TERM_NB:
            begin
                x = OP_BITS'(b_reg);
                y = OP_BITS'(b_reg);
            end
            TERM_DOT:
            begin
                x = OP_BITS'(a_reg);
                y = OP_BITS'(b_reg);
            end
        endcase
    end

    // One adder serves all four accumulators, one term per cycle.
    always_comb
    begin
        term_ext = SUM_BITS'(prod_reg[SQ_BITS-1:0]);
        unique case (sel_reg)
            TERM_DIFF: acc_ext = {1'b0, acc_reg.diff_sq};
            TERM_NA:   acc_ext = {1'b0, acc_reg.norm_a};
            TERM_NB:   acc_ext = {1'b0, acc_reg.norm_b};
            TERM_DOT:
            begin
                acc_ext  = {acc_reg.dot[ACC_BITS-1], acc_reg.dot};
                term_ext = SUM_BITS'(prod_reg);
            end
        endcase
        sum    = acc_ext + term_ext;
        is_dot = (sel_reg == TERM_DOT);
        if (is_dot)
        begin
            sat     = (sum[SUM_BITS-1] != sum[SUM_BITS-2]);
            sat_val = sum[SUM_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                      : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        else
        begin
            sat     = sum[SUM_BITS-1];
            sat_val = '1;
        end
        new_val = sat ? sat_val : sum[ACC_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            step_reg <= TERM_DIFF;
            sel_reg  <= TERM_DIFF;
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pv_reg <= run_reg;
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                step_reg <= TERM_DIFF;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                prod_reg <= x * y;
                sel_reg  <= step_reg;
                step_reg <= term_t'(step_reg + 2'd1);
                if (step_reg == TERM_DOT)
                begin
                    run_reg <= 1'b0;
                end
            end

            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                if (sat)
                begin
                    acc_reg.ovf <= 1'b1;
                end
                unique case (sel_reg)
                    TERM_DIFF: acc_reg.diff_sq <= new_val;
                    TERM_NA:   acc_reg.norm_a  <= new_val;
                    TERM_NB:   acc_reg.norm_b  <= new_val;
                    TERM_DOT:  acc_reg.dot     <= new_val;
                endcase
            end
        end
    end

    assign done = pv_reg && (sel_reg == TERM_DOT);
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/fvd_sqrt.sv =====
// Digit-by-digit floor square root, two radicand bits per cycle.
`default_nettype none

module fvd_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [fvd_pkg::ACC_BITS-1:0]   value,
    output logic                                done,
    output logic [fvd_pkg::ROOT_BITS-1:0]       root
);
    import fvd_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS);

    logic                run_reg, done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [ACC_BITS-1:0] rem_reg, root_reg;
    logic [ACC_BITS-1:0] bit_val, trial;

    always_comb
    begin
        bit_val = ACC_BITS'(1) << {cnt_reg, 1'b0};
        trial   = root_reg + bit_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= value;
                root_reg <= '0;
                cnt_reg  <= CNT_BITS'(ROOT_BITS - 1);
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_val;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/fvd_div.sv =====
// Restoring divider producing the fractional bits of a proper ratio.
`default_nettype none

module fvd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [fvd_pkg::ACC_BITS-1:0]   dividend,
    input  wire logic [fvd_pkg::ACC_BITS-1:0]   divisor,
    output logic                                done,
    output logic [fvd_pkg::FRAC_BITS-1:0]       quotient
);
    import fvd_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS);

    logic                 run_reg, done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [ACC_BITS-1:0]  rem_reg;
    logic [ACC_BITS-1:0]  den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [ACC_BITS:0]    shifted;

    // Remainder stays below the divisor, so one extra bit holds the shift.
    assign shifted = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= dividend;
                den_reg <= divisor;
                q_reg   <= '0;
                cnt_reg <= CNT_BITS'(FRAC_BITS - 1);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_reg <= ACC_BITS'(shifted - {1'b0, den_reg});
                    q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[ACC_BITS-1:0];
                    q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== hdl/feature_vector_distance_unit.sv =====
// Top level of the feature vector distance unit: sequencer and result register.
//
// Input channel (in_valid / in_stall / in_item): one element pair per item,
// last marks the final pair of the two vectors. Output channel (out_valid /
// out_stall / out_item): one result per vector, given on the last item.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the distance
// kind: euclidean, squared euclidean or cosine; write it only while idle.
// Each item occupies the block while the MAC runs: one shared 17x17 multiplier
// forms the four products in turn and one shared adder folds them into the
// saturating accumulators. On a last item the result is taken directly from
// the squared accumulator in squared mode, after a square root in euclidean
// mode, and after two square roots, one multiply and a divide in cosine mode
// (a zero norm skips the multiply and the divide, a clamped ratio the divide).
// The next item is taken once the sequencer is back in idle after the result loads.
// Reset clears the accumulators, selects euclidean mode and empties the
// output register. A stalled result holds in the output register; the next
// vector's items are still taken, and a further result waits in the
// sequencer until the register frees.
`default_nettype none

module feature_vector_distance_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire fvd_pkg::in_item_t                 in_item,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output fvd_pkg::out_item_t                     out_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fvd_pkg::KIND_BITS-1:0]     cfg_data
);
    import fvd_pkg::*;

    localparam logic [ACC_BITS-1:0] ONE_Q  = ACC_BITS'(1) << FRAC_BITS;
    localparam logic [ACC_BITS-1:0] TWO_Q  = ACC_BITS'(1) << (FRAC_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_SEL, S_SQ_DIFF, S_SQ_A, S_SQ_B, S_MUL, S_CMP, S_DIV, S_OUT
    } state_t;

    state_t                state_reg;
    logic [KIND_BITS-1:0]  kind_reg;
    logic                  last_reg;
    logic [ROOT_BITS-1:0]  na_reg, nb_reg;
    logic [ACC_BITS-1:0]   den_reg, mag_reg, res_reg;
    logic                  neg_reg, zero_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic                  in_accept, out_free;
    logic                  mac_done, mac_clear;
    acc_t                  acc;
    logic                  sqrt_start, sqrt_done;
    logic [ACC_BITS-1:0]   sqrt_value;
    logic [ROOT_BITS-1:0]  root;
    logic                  div_start, div_done;
    logic [FRAC_BITS-1:0]  quotient;
    logic [ACC_BITS-1:0]   den_prod;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mac_clear = (state_reg == S_OUT) && out_free;
    assign den_prod  = na_reg * nb_reg;

    fvd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .a     (in_item.elem_a),
        .b     (in_item.elem_b),
        .clear (mac_clear),
        .done  (mac_done),
        .acc   (acc)
    );

    fvd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sqrt_value),
        .done  (sqrt_done),
        .root  (root)
    );

    fvd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        sqrt_start = 1'b0;
        sqrt_value = acc.diff_sq;
        div_start  = 1'b0;
        unique case (state_reg)
            S_SEL:
            begin
                if (kind_reg == KIND_COSINE)
                begin
                    sqrt_start = 1'b1;
                    sqrt_value = acc.norm_a;
                end
                else if (kind_reg != KIND_SQUARED)
                begin
                    sqrt_start = 1'b1;
                end
            end
            S_SQ_A:
            begin
                if (sqrt_done)
                begin
                    sqrt_start = 1'b1;
                    sqrt_value = acc.norm_b;
                end
            end
            S_CMP:
            begin
                div_start = (mag_reg < den_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_EUCLID;
            last_reg      <= 1'b0;
            na_reg        <= '0;
            nb_reg        <= '0;
            den_reg       <= '0;
            mag_reg       <= '0;
            res_reg       <= '0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                kind_reg <= cfg_data;
            end

            // Drop a taken result unless a new one loads at this edge.
            if (out_valid_reg && !out_stall && !((state_reg == S_OUT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        last_reg  <= in_item.last;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (mac_done)
                    begin
                        state_reg <= last_reg ? S_SEL : S_IDLE;
                    end
                end
                S_SEL:
                begin
                    zero_reg <= 1'b0;
                    if (kind_reg == KIND_COSINE)
                    begin
                        state_reg <= S_SQ_A;
                    end
                    else if (kind_reg == KIND_SQUARED)
                    begin
                        res_reg   <= acc.diff_sq;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SQ_DIFF;
                    end
                end
                S_SQ_DIFF:
                begin
                    if (sqrt_done)
                    begin
                        res_reg   <= ACC_BITS'(root);
                        state_reg <= S_OUT;
                    end
                end
                S_SQ_A:
                begin
                    if (sqrt_done)
                    begin
                        na_reg    <= root;
                        state_reg <= S_SQ_B;
                    end
                end
                S_SQ_B:
                begin
                    if (sqrt_done)
                    begin
                        nb_reg <= root;
                        if (na_reg == '0 || root == '0)
                        begin
                            res_reg   <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    den_reg   <= den_prod;
                    neg_reg   <= acc.dot[ACC_BITS-1];
                    mag_reg   <= acc.dot[ACC_BITS-1] ? ACC_BITS'(-acc.dot) : acc.dot;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // Clamp a ratio at or beyond one in magnitude.
                    if (mag_reg >= den_reg)
                    begin
                        res_reg   <= neg_reg ? TWO_Q : '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= neg_reg ? ONE_Q + ACC_BITS'(quotient)
                                             : ONE_Q - ACC_BITS'(quotient);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.distance  <= res_reg;
                        out_item_reg.zero_norm <= zero_reg;
                        out_item_reg.saturated <= acc.ovf;
                        state_reg              <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
